### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked while reset is released
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every clock edge, reset included
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(name, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

### sv/esai_pkg.sv
// ----------------------------------------------------------------------------
// esai_pkg
// shared types and constants of the strided address iterator
// ----------------------------------------------------------------------------
`default_nettype none

package esai_pkg;

  // default sizing
  localparam int unsigned DefMaxSymbols = 8;
  localparam int unsigned DefMaxTensors = 4;

  // field widths
  localparam int unsigned ActionW   = 3;
  localparam int unsigned SymFieldW = 3;
  localparam int unsigned TenFieldW = 2;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned StrideW   = 24;
  localparam int unsigned ExtentW   = 16;
  localparam int unsigned CounterW  = 16;

  // configuration registers
  localparam int unsigned SymCntW  = 4;
  localparam int unsigned TenCntW  = 3;
  localparam int unsigned ElemW    = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYMBOL_COUNT  = 2'd0,
    CFG_TENSOR_COUNT  = 2'd1,
    CFG_ELEMENT_BYTES = 2'd2
  } cfg_reg_e;

  typedef enum logic [ActionW-1:0] {
    ACT_LOAD_STRIDE = 3'd0,
    ACT_LOAD_EXTENT = 3'd1,
    ACT_LOAD_BASE   = 3'd2,
    ACT_START       = 3'd3,
    ACT_STEP        = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INCR,
    ST_MOVE_RD,
    ST_MOVE_MUL1,
    ST_MOVE_MUL2,
    ST_MOVE_WB,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

### sv/esai_ram.sv
// ----------------------------------------------------------------------------
// esai_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module esai_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 32,
  localparam int unsigned RamAW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [RamAW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [RamAW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/einsum_strided_address_iterator.sv
// ----------------------------------------------------------------------------
// einsum_strided_address_iterator
// odometer-style address generator for tensor contraction loops
// ----------------------------------------------------------------------------
// Usage: drive action/symbol/tensor/value/level and raise start; the
// transaction is taken at a clock edge with start high and busy low.
// Loads of stride, extent and base address and the start action finish in
// the accepting cycle and give no result. A step keeps busy high while it
// scans symbols of the requested level and updates the tensor addresses,
// then emits one result per tensor in use on consecutive cycles, marked by
// result_valid_o, with last_o on the final one.
// Each tensor address update goes through stride ram read, stride times
// element size, times the step factor, write back. The stride table sits in
// a registered-read ram. Busy drops while the last result is on the ports,
// so the next transaction can be taken at the edge that takes that result.
// The configuration port is written at a clock edge with cfg_we_i high and
// is to be used by the user only while busy is low; the block does not
// enforce this.
// Reset clears the index counters and sets the registers to one symbol,
// two tensors, one byte per element; strides, extents and base addresses
// must be loaded before use. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module einsum_strided_address_iterator #(
  parameter int unsigned MAX_SYMBOLS = esai_pkg::DefMaxSymbols,
  parameter int unsigned MAX_TENSORS = esai_pkg::DefMaxTensors
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [esai_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [esai_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [esai_pkg::ActionW-1:0]    action_i,
  input  logic [esai_pkg::SymFieldW-1:0]  symbol_i,
  input  logic [esai_pkg::TenFieldW-1:0]  tensor_i,
  input  logic [esai_pkg::ValueW-1:0]     value_i,
  input  logic                            level_i,
  // result channel
  output logic                            result_valid_o,
  output logic [esai_pkg::TenFieldW-1:0]  tensor_index_o,
  output logic [esai_pkg::AddrW-1:0]      address_o,
  output logic                            more_o,
  output logic                            last_o
);

  import esai_pkg::*;

  localparam int unsigned KW     = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned SymW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned TIW    = $clog2(MAX_TENSORS);
  localparam int unsigned TUW    = $clog2(MAX_TENSORS + 1);
  localparam int unsigned Entries = MAX_SYMBOLS * MAX_TENSORS;
  localparam int unsigned RamAW  = $clog2(Entries);

  // configuration registers
  logic [SymCntW-1:0] sym_cnt_q;
  logic [TenCntW-1:0] ten_cnt_q;
  logic [ElemW-1:0]   elem_bytes_q;

  // sequencer and datapath registers
  state_e             state_q, state_d;
  logic [KW-1:0]      k_q, k_d;
  logic [TIW-1:0]     j_q, j_d;
  logic               lvl_q, lvl_d;
  logic               sub_q, sub_d;
  logic               more_q, more_d;
  logic [AddrW-1:0]   factor_q, factor_d;
  logic [AddrW-1:0]   p1_q, p1_d;
  logic [AddrW-1:0]   p2_q, p2_d;

  // per-symbol and per-tensor state
  logic [CounterW-1:0] cnt_q  [MAX_SYMBOLS];
  logic [ExtentW-1:0]  ext_q  [MAX_SYMBOLS];
  logic [AddrW-1:0]    addr_q [MAX_TENSORS];
  logic                zflag_q [Entries];

  // result registers
  logic                 out_valid_q, out_valid_d;
  logic                 out_last_q, out_last_d;
  logic                 out_more_q, out_more_d;
  logic [TenFieldW-1:0] out_idx_q, out_idx_d;
  logic [AddrW-1:0]     out_addr_q, out_addr_d;

  // write controls for the arrays
  logic                ram_we;
  logic [RamAW-1:0]    ram_waddr, ram_raddr;
  logic [StrideW-1:0]  ram_rdata;
  logic                cnt_clr, cnt_we;
  logic [CounterW-1:0] cnt_wval;
  logic                ext_we;
  logic                addr_we;
  logic [TIW-1:0]      addr_widx;
  logic [AddrW-1:0]    addr_wval;

  // decoded helpers
  action_e             act;
  logic                accept;
  logic                sym_ok, ten_ok;
  logic [KW-1:0]       n_used;
  logic [TUW-1:0]      t_used;
  logic [SymW-1:0]     k_idx;
  logic [RamAW-1:0]    flag_idx;
  logic                lvl_flag;
  logic [CounterW-1:0] cnt_inc;
  logic                last_j;

  assign act    = action_e'(action_i);
  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign sym_ok = (32'(symbol_i) < MAX_SYMBOLS);
  assign ten_ok = (32'(tensor_i) < MAX_TENSORS);

  // symbols and tensors in use, clamped to the sizing, tensors at least two
  assign n_used = (32'(sym_cnt_q) > MAX_SYMBOLS) ? KW'(MAX_SYMBOLS) : KW'(sym_cnt_q);
  always_comb begin
    if (ten_cnt_q < 3'd2) begin
      t_used = TUW'(2);
    end else if (32'(ten_cnt_q) > MAX_TENSORS) begin
      t_used = TUW'(MAX_TENSORS);
    end else begin
      t_used = TUW'(ten_cnt_q);
    end
  end

  // symbol level taken from the zero flag of the output tensor stride
  assign k_idx    = k_q[SymW-1:0];
  assign flag_idx = RamAW'((32'(t_used) - 32'd1) * MAX_SYMBOLS + 32'(k_q));
  assign lvl_flag = zflag_q[flag_idx];
  assign cnt_inc  = cnt_q[k_idx] + CounterW'(1);
  assign last_j   = ((32'(j_q) + 32'd1) == 32'(t_used));

  // stride table addressing
  assign ram_waddr = RamAW'(32'(tensor_i) * MAX_SYMBOLS + 32'(symbol_i));
  assign ram_raddr = RamAW'(32'(j_q) * MAX_SYMBOLS + 32'(k_q));

  esai_ram #(
    .Width (StrideW),
    .Depth (Entries)
  ) u_stride_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i[StrideW-1:0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (act == ACT_STEP)) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (k_q >= n_used) begin
          state_d = ST_EMIT;
        end else if (lvl_flag == lvl_q) begin
          state_d = ST_INCR;
        end
      end
      ST_INCR:      state_d = ST_MOVE_RD;
      ST_MOVE_RD:   state_d = ST_MOVE_MUL1;
      ST_MOVE_MUL1: state_d = ST_MOVE_MUL2;
      ST_MOVE_MUL2: state_d = ST_MOVE_WB;
      ST_MOVE_WB: begin
        if (!last_j) begin
          state_d = ST_MOVE_RD;
        end else if (sub_q) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (last_j) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath controls and next values
  always_comb begin
    k_d         = k_q;
    j_d         = j_q;
    lvl_d       = lvl_q;
    sub_d       = sub_q;
    more_d      = more_q;
    factor_d    = factor_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    ram_we      = 1'b0;
    cnt_clr     = 1'b0;
    cnt_we      = 1'b0;
    cnt_wval    = cnt_inc;
    ext_we      = 1'b0;
    addr_we     = 1'b0;
    addr_widx   = j_q;
    addr_wval   = sub_q ? (addr_q[j_q] - p2_q) : (addr_q[j_q] + p2_q);
    out_valid_d = 1'b0;
    out_last_d  = 1'b0;
    out_more_d  = out_more_q;
    out_idx_d   = out_idx_q;
    out_addr_d  = out_addr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_LOAD_STRIDE: ram_we = sym_ok && ten_ok;
            ACT_LOAD_EXTENT: ext_we = sym_ok;
            ACT_LOAD_BASE: begin
              addr_we   = ten_ok;
              addr_widx = TIW'(tensor_i);
              addr_wval = value_i;
            end
            ACT_START: cnt_clr = 1'b1;
            ACT_STEP: begin
              k_d   = '0;
              lvl_d = level_i;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // level exhausted, or skip a symbol of the other level
        if (k_q >= n_used) begin
          more_d = 1'b0;
          j_d    = '0;
        end else if (lvl_flag != lvl_q) begin
          k_d = k_q + KW'(1);
        end
      end
      ST_INCR: begin
        cnt_we = 1'b1;
        j_d    = '0;
        if (cnt_inc < ext_q[k_idx]) begin
          factor_d = AddrW'(1);
          sub_d    = 1'b0;
          more_d   = 1'b1;
        end else begin
          // wrap: rewind by extent minus one strides
          cnt_wval = '0;
          factor_d = AddrW'(ext_q[k_idx]) - AddrW'(1);
          sub_d    = 1'b1;
        end
      end
      ST_MOVE_MUL1: p1_d = AddrW'(ram_rdata) * AddrW'(elem_bytes_q);
      ST_MOVE_MUL2: p2_d = p1_q * factor_q;
      ST_MOVE_WB: begin
        addr_we = 1'b1;
        if (last_j) begin
          j_d = '0;
          if (sub_q) k_d = k_q + KW'(1);
        end else begin
          j_d = j_q + TIW'(1);
        end
      end
      ST_EMIT: begin
        out_valid_d = 1'b1;
        out_last_d  = last_j;
        out_more_d  = more_q;
        out_idx_d   = TenFieldW'(j_q);
        out_addr_d  = addr_q[j_q];
        j_d         = j_q + TIW'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_cnt_q    <= SymCntW'(1);
      ten_cnt_q    <= TenCntW'(2);
      elem_bytes_q <= ElemW'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_SYMBOL_COUNT:  sym_cnt_q    <= cfg_wdata_i[SymCntW-1:0];
        CFG_TENSOR_COUNT:  ten_cnt_q    <= cfg_wdata_i[TenCntW-1:0];
        CFG_ELEMENT_BYTES: elem_bytes_q <= cfg_wdata_i[ElemW-1:0];
        default: ;
      endcase
    end
  end

  // index counters, cleared by reset and by the start action
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SYMBOLS; i++) cnt_q[i] <= '0;
    end else if (cnt_clr) begin
      for (int i = 0; i < MAX_SYMBOLS; i++) cnt_q[i] <= '0;
    end else if (cnt_we) begin
      cnt_q[k_idx] <= cnt_wval;
    end
  end

  // datapath, extents, addresses and stride zero flags
  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    j_q        <= j_d;
    lvl_q      <= lvl_d;
    sub_q      <= sub_d;
    more_q     <= more_d;
    factor_q   <= factor_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    out_more_q <= out_more_d;
    out_idx_q  <= out_idx_d;
    out_addr_q <= out_addr_d;
    if (ext_we) ext_q[SymW'(symbol_i)] <= value_i[ExtentW-1:0];
    if (addr_we) addr_q[addr_widx] <= addr_wval;
    if (ram_we) zflag_q[ram_waddr] <= (value_i[StrideW-1:0] == '0);
  end

  assign result_valid_o = out_valid_q;
  assign tensor_index_o = out_idx_q;
  assign address_o      = out_addr_q;
  assign more_o         = out_more_q;
  assign last_o         = out_last_q;

  // assertions
  `ASSERT_RST(a_result_from_emit, clk_i, rst_ni, out_valid_q |-> $past(state_q == ST_EMIT), "result without emit")
  `ASSERT_RST(a_gap_after_last, clk_i, rst_ni, (out_valid_q && out_last_q) |=> !out_valid_q, "result after last")
  `ASSERT_RST(a_busy_mid_burst, clk_i, rst_ni, (out_valid_q && !out_last_q) |-> busy, "idle in result burst")
  `ASSERT_RST(a_wb_after_mul, clk_i, rst_ni, (state_q == ST_MOVE_WB) |-> $past(state_q == ST_MOVE_MUL2), "write back out of order")
  `ASSERT_ALWAYS(a_last_is_valid, clk_i, out_last_q |-> out_valid_q, "last without strobe")

endmodule

`default_nettype wire
